// File: rtl/dq_pkg.sv
package dq_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               is_empty;
	} rsp_t;

	// bookkeeping for a word whose read data is still in flight
	typedef struct packed {
		logic               valid;
		logic               use_rd;
		logic [1:0]         status;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
	} meta_t;

endpackage

// File: rtl/double_ended_queue_core.sv
// Channel   Ports               Handshake
// request   start, busy, req    taken on a rising edge with start high and busy low
// result    done, rsp           valid for the one cycle that done is high
//
// Each request yields one result word in the cycle after acceptance,
// in step with the registered read port of the ring store.
// A new request may be taken in every cycle, so busy is held low.
// Reset clears the head pointer and the entry count; store contents stay
// undefined, but only written entries are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dq_pkg::req_t req,
	output logic         done,
	output dq_pkg::rsp_t rsp
);
	import dq_pkg::*;

	logic              accept;
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;
	meta_t             meta_s1;

	// never stall the requester: every operation touches one entry only
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// pointer and count bookkeeping; issue the store access for this word
	dq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.meta_s1 (meta_s1)
	);

	// ring store; a write and a read in the same cycle never share an entry,
	// and a read in the following cycle sees the committed write
	dq_ram #(
		.AW (IDX_W),
		.DW (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// assemble the result word: read data only for a successful pop or peek
	assign done             = meta_s1.valid;
	assign rsp.read_value   = meta_s1.use_rd ? 32'(signed'(ram_rdata)) : '0;
	assign rsp.status       = meta_s1.status;
	assign rsp.entry_count  = meta_s1.entry_count;
	assign rsp.is_empty     = meta_s1.is_empty;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result strobe without an accepted request");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OVERFLOW) |-> (rsp.entry_count == COUNT_W'(DEPTH)))
		else $error("overflow reported while not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_underflow_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_UNDERFLOW) |-> (rsp.is_empty && rsp.read_value == '0))
		else $error("underflow with data or entries");

endmodule

// File: rtl/dq_ram.sv
module dq_ram #(
	parameter int AW = 4,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/dq_ctrl.sv
module dq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  dq_pkg::req_t                        req,
	output logic                                we,
	output logic [dq_pkg::IDX_W-1:0]            waddr,
	output logic [dq_pkg::DATA_W-1:0]           wdata,
	output logic                                re,
	output logic [dq_pkg::IDX_W-1:0]            raddr,
	output dq_pkg::meta_t                       meta_s1
);
	import dq_pkg::*;

	logic [IDX_W-1:0] head_q, head_nxt;
	logic [CNT_W-1:0] occ_q, occ_nxt;
	logic [IDX_W-1:0] head_m1, head_p1, tail, rear;
	logic             full, empty;
	status_t          st;
	logic             rd_use;
	meta_t            meta_nxt;

	// fold a sum below twice the depth back into the ring
	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] s);
		logic [IDX_W:0] r;
		r = (s >= (IDX_W+1)'(DEPTH)) ? s - (IDX_W+1)'(DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	assign full    = (occ_q == CNT_W'(DEPTH));
	assign empty   = (occ_q == '0);
	assign head_m1 = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_p1 = wrap({1'b0, head_q} + (IDX_W+1)'(1));
	assign tail    = wrap({1'b0, head_q} + (IDX_W+1)'(occ_q));
	assign rear    = wrap({1'b0, head_q} + (IDX_W+1)'(occ_q) - (IDX_W+1)'(1));

	always_comb begin
		head_nxt = head_q;
		occ_nxt  = occ_q;
		we       = 1'b0;
		waddr    = tail;
		wdata    = DATA_W'(req.push_value);
		re       = 1'b0;
		raddr    = head_q;
		rd_use   = 1'b0;
		st       = ST_OK;
		unique case (op_t'(req.operation))
			OP_PUSH_FRONT: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					we       = accept;
					waddr    = head_m1;
					head_nxt = head_m1;
					occ_nxt  = occ_q + 1'b1;
				end
			end
			OP_PUSH_REAR: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					we      = accept;
					occ_nxt = occ_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					re       = accept;
					rd_use   = 1'b1;
					head_nxt = head_p1;
					occ_nxt  = occ_q - 1'b1;
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					re      = accept;
					rd_use  = 1'b1;
					raddr   = rear;
					occ_nxt = occ_q - 1'b1;
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					re     = accept;
					rd_use = 1'b1;
				end
			end
			default: begin
			end
		endcase
		meta_nxt.valid       = accept;
		meta_nxt.use_rd      = rd_use;
		meta_nxt.status      = st;
		meta_nxt.entry_count = COUNT_W'(occ_nxt);
		meta_nxt.is_empty    = (occ_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			occ_q   <= '0;
			meta_s1 <= '0;
		end else begin
			meta_s1 <= meta_nxt;
			if (accept) begin
				head_q <= head_nxt;
				occ_q  <= occ_nxt;
			end
		end
	end

endmodule
